// File: rtl/framebuffer_raster_engine_assert.svh
// Assertion macros shared by the raster engine modules.
`ifndef FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication check.
`define FBRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define FBRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FBRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FBRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/fbre_pkg.sv
// Shared types and constants of the frame buffer raster engine.
`timescale 1ns / 1ps
`default_nettype none

package fbre_pkg;

	localparam int unsigned PIX_W     = 16;
	localparam int unsigned COORD_W   = 8;
	localparam int unsigned SGN_W     = 10;
	localparam int unsigned PAGE_ROWS = 8;

	localparam logic [PIX_W-1:0] PIXEL_MASK = 16'hffff;

	// Command kinds carried with each input transaction
	typedef enum logic [1:0] {
		ACT_FILL   = 2'd0,
		ACT_INVERT = 2'd1,
		ACT_GLYPH  = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	// Result status codes
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_OFF_SCREEN = 2'd1;
	localparam logic [1:0] ST_CLIPPED    = 2'd2;

	// Register indexes of the configuration port
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BACK_COLOR    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_X        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_Y        = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_WIDTH    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_HEIGHT   = 3'd7;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;
		logic load;
		logic setup;
		logic base;
		logic walk;
		logic drain;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic empty;
		logic walk_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/framebuffer_raster_engine.sv
// Top level of the frame buffer raster engine.
`timescale 1ns / 1ps
`default_nettype none

// RGB565 frame store of MAX_WIDTH * MAX_HEIGHT pixels with a command stream
// for rectangle fill, rectangle invert, glyph column writes and pixel reads;
// every command returns one result transaction. After reset the block clears
// the whole store, one pixel a cycle, before it takes the first command
// (configuration writes are taken throughout). A command walks the rectangle
// clipped to the screen for fill and invert, the on-screen rows (up to 8,
// whatever the column bits) of an on-screen column that passes the clip test
// for a glyph, and the pixel of an on-screen read; a command with no pixel to
// walk goes straight to its result. The walk visits one pixel a cycle on
// the single store write port, with invert reading one pixel ahead of its
// write. One result may wait in the output register while the next command
// is accepted and worked on.
module framebuffer_raster_engine
	import fbre_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 128,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// configuration
	input  wire                 cfg_wen,
	input  wire [REG_IDX_W-1:0] cfg_index,
	input  wire [PIX_W-1:0]     cfg_data,
	// command stream
	input  wire                 s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire [47:0]          s_axis_tdata,   // pos_x, pos_y, size_w, size_h, glyph_bits
	input  wire [1:0]           s_axis_tuser,   // action
	// result stream
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // pixel_data
	output logic [1:0]          m_axis_tuser    // status
);

	localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AddrW = $clog2(Depth);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic             st_wr_en, st_rd_en;
	logic [AddrW-1:0] st_wr_addr, st_rd_addr;
	logic [PIX_W-1:0] st_wr_data, st_rd_data;

	fbre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fbre_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (s_axis_tuser),
		.pos_x      (s_axis_tdata[8:0]),
		.pos_y      (s_axis_tdata[17:9]),
		.size_w     (s_axis_tdata[25:18]),
		.size_h     (s_axis_tdata[33:26]),
		.glyph_bits (s_axis_tdata[41:34]),
		.pixel_data (m_axis_tdata),
		.status     (m_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.st_wr_en   (st_wr_en),
		.st_wr_addr (st_wr_addr),
		.st_wr_data (st_wr_data),
		.st_rd_en   (st_rd_en),
		.st_rd_addr (st_rd_addr),
		.st_rd_data (st_rd_data)
	);

	fbre_store #(
		.DEPTH  (Depth),
		.ADDR_W (AddrW)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

endmodule

`default_nettype wire

// File: rtl/fbre_store.sv
// Pixel store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fbre_store
	import fbre_pkg::*;
#(
	parameter int unsigned DEPTH  = 8192,
	parameter int unsigned ADDR_W = 13
) (
	input  wire              clk,
	input  wire              wr_en,
	input  wire [ADDR_W-1:0] wr_addr,
	input  wire [PIX_W-1:0]  wr_data,
	input  wire              rd_en,
	input  wire [ADDR_W-1:0] rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/fbre_ctrl.sv
// Controller state machine of the raster engine.
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_raster_engine_assert.svh"

module fbre_ctrl
	import fbre_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  wire     out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_BASE,
		S_WALK,
		S_DRAIN,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit;

	// Hand the finished result over once the output register is free
	assign emit     = (state_q == S_RESULT) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd       = '0;
		cmd.clear = (state_q == S_CLEAR);
		cmd.load  = (state_q == S_IDLE) && in_valid;
		cmd.setup = (state_q == S_SETUP);
		cmd.base  = (state_q == S_BASE);
		cmd.walk  = (state_q == S_WALK);
		cmd.drain = (state_q == S_DRAIN);
		cmd.emit  = emit;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_BASE;
				end
				S_BASE: begin
					state_q <= sts.empty ? S_RESULT : S_WALK;
				end
				S_WALK: begin
					if (sts.walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FBRE_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, emit, !out_valid_q || out_ready, "result overwrites a waiting result")
	`FBRE_ASSERT_NEXT(a_walk_ends, clk, arst_n, (state_q == S_WALK) && sts.walk_last, state_q == S_DRAIN, "walk did not end on its last pixel")
	`FBRE_ASSERT_IMPLY(a_clear_quiet, clk, arst_n, state_q == S_CLEAR, !out_valid_q, "result pending during clearing pass")

endmodule

`default_nettype wire

// File: rtl/fbre_datapath.sv
// Datapath: configuration registers, clipping, pixel walk and result registers.
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_raster_engine_assert.svh"

module fbre_datapath
	import fbre_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 128,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// configuration port
	input  wire                            cfg_wen,
	input  wire [REG_IDX_W-1:0]            cfg_index,
	input  wire [PIX_W-1:0]                cfg_data,
	// command fields
	input  wire [1:0]                      action,
	input  wire [8:0]                      pos_x,
	input  wire [8:0]                      pos_y,
	input  wire [7:0]                      size_w,
	input  wire [7:0]                      size_h,
	input  wire [7:0]                      glyph_bits,
	// result
	output logic [PIX_W-1:0]               pixel_data,
	output logic [1:0]                     status,
	// control
	input  dp_cmd_t                        cmd,
	output dp_sts_t                        sts,
	// store ports
	output logic                           st_wr_en,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] st_wr_addr,
	output logic [PIX_W-1:0]               st_wr_data,
	output logic                           st_rd_en,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] st_rd_addr,
	input  wire [PIX_W-1:0]                st_rd_data
);

	localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AddrW = $clog2(Depth);
	localparam logic [COORD_W-1:0] MaxW = COORD_W'(MAX_WIDTH);
	localparam logic [COORD_W-1:0] MaxH = COORD_W'(MAX_HEIGHT);

	// configuration registers
	logic [PIX_W-1:0]   back_color_q, text_color_q;
	logic [7:0]         screen_width_q;
	logic [6:0]         screen_height_q;
	logic [7:0]         clip_x_q, clip_y_q, clip_width_q, clip_height_q;

	// command registers
	action_t            action_q;
	logic [8:0]         pos_x_q, pos_y_q;
	logic [7:0]         size_w_q, size_h_q, bits_q;

	// walk bounds and counters
	logic [COORD_W-1:0] x0_q, xlast_q, ylast_q, y0_q;
	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [2:0]         j_q;
	logic               empty_q;
	logic [AddrW-1:0]   row_base_q;
	logic [AddrW-1:0]   clr_cnt_q;

	// write stage
	logic               wr_en_s1;
	logic [AddrW-1:0]   addr_s1;

	// result registers
	logic [PIX_W-1:0]   res_pixel_q, out_pixel_q;
	logic [1:0]         res_status_q, out_status_q;

	// combinational
	logic [COORD_W-1:0]       effw, effh;
	logic signed [SGN_W-1:0]  px, py, effw_s, effh_s;
	logic signed [SGN_W-1:0]  xs, xe, ys, ye, cx_end, cy_end;
	logic                     force_empty;
	logic [1:0]               stat_c;
	logic [15:0]              base_prod;
	logic [AddrW-1:0]         pix_addr;
	logic                     row_end, pix_we;

	// Effective screen size
	assign effw = (screen_width_q > MaxW) ? MaxW : screen_width_q;
	assign effh = ({1'b0, screen_height_q} > MaxH) ? MaxH : {1'b0, screen_height_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_color_q    <= '0;
			text_color_q    <= '0;
			screen_width_q  <= 8'd128;
			screen_height_q <= 7'd64;
			clip_x_q        <= '0;
			clip_y_q        <= '0;
			clip_width_q    <= 8'd128;
			clip_height_q   <= 8'd64;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_BACK_COLOR:    back_color_q    <= cfg_data;
				REG_TEXT_COLOR:    text_color_q    <= cfg_data;
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[7:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[6:0];
				REG_CLIP_X:        clip_x_q        <= cfg_data[7:0];
				REG_CLIP_Y:        clip_y_q        <= cfg_data[7:0];
				REG_CLIP_WIDTH:    clip_width_q    <= cfg_data[7:0];
				REG_CLIP_HEIGHT:   clip_height_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Work out the clipped pixel range of the held command
	always_comb begin
		px     = signed'({pos_x_q[8], pos_x_q});
		py     = signed'({pos_y_q[8], pos_y_q});
		effw_s = signed'({2'b00, effw});
		effh_s = signed'({2'b00, effh});
		cx_end = signed'({2'b00, clip_x_q} + {2'b00, clip_width_q});
		cy_end = signed'({2'b00, clip_y_q} + {2'b00, clip_height_q});
		force_empty = 1'b0;
		stat_c = ST_DONE;
		xs = px;
		ys = py;
		xe = px + SGN_W'(1);
		ye = py + SGN_W'(1);
		case (action_q)
			ACT_FILL, ACT_INVERT: begin
				xs = (px < 0) ? '0 : px;
				ys = (py < 0) ? '0 : py;
				xe = px + signed'({2'b00, size_w_q});
				ye = py + signed'({2'b00, size_h_q});
				if (xe > effw_s) xe = effw_s;
				if (ye > effh_s) ye = effh_s;
			end
			ACT_GLYPH: begin
				ye = py + SGN_W'(PAGE_ROWS);
				if (xe > effw_s) xe = effw_s;
				if (ye > effh_s) ye = effh_s;
				if (px < signed'({2'b00, clip_x_q}) || px >= cx_end ||
				    py < signed'({2'b00, clip_y_q}) || py >= cy_end) begin
					force_empty = 1'b1;
					stat_c = ST_CLIPPED;
				end
			end
			ACT_READ: begin
				if (px < 0 || py < 0 || px >= effw_s || py >= effh_s) begin
					force_empty = 1'b1;
					stat_c = ST_OFF_SCREEN;
				end
			end
			default: ;
		endcase
	end

	// Walk addressing and per-pixel write decision
	assign base_prod = y0_q * effw;
	assign pix_addr  = row_base_q + AddrW'(cur_x_q);
	assign row_end   = (cur_x_q == xlast_q);
	always_comb begin
		case (action_q)
			ACT_FILL, ACT_INVERT: pix_we = 1'b1;
			ACT_GLYPH:            pix_we = bits_q[j_q];
			default:              pix_we = 1'b0;
		endcase
	end

	// Latch the command fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(action);
			pos_x_q  <= pos_x;
			pos_y_q  <= pos_y;
			size_w_q <= size_w;
			size_h_q <= size_h;
			bits_q   <= glyph_bits;
		end
	end

	// Bounds, counters and results
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x0_q         <= xs[COORD_W-1:0];
			y0_q         <= ys[COORD_W-1:0];
			xlast_q      <= COORD_W'(xe - SGN_W'(1));
			ylast_q      <= COORD_W'(ye - SGN_W'(1));
			empty_q      <= force_empty || (xe <= xs) || (ye <= ys);
			res_status_q <= stat_c;
			res_pixel_q  <= '0;
		end
		if (cmd.base) begin
			row_base_q <= AddrW'(base_prod);
			cur_x_q    <= x0_q;
			cur_y_q    <= y0_q;
			j_q        <= '0;
		end
		// Advance one pixel, row by row
		if (cmd.walk) begin
			addr_s1 <= pix_addr;
			if (row_end) begin
				cur_x_q    <= x0_q;
				cur_y_q    <= cur_y_q + COORD_W'(1);
				row_base_q <= row_base_q + AddrW'(effw);
				j_q        <= j_q + 3'd1;
			end else begin
				cur_x_q <= cur_x_q + COORD_W'(1);
			end
		end
		// Capture the pixel read by a read command
		if (cmd.drain && (action_q == ACT_READ)) begin
			res_pixel_q <= st_rd_data;
		end
		if (cmd.emit) begin
			out_pixel_q  <= res_pixel_q;
			out_status_q <= res_status_q;
		end
	end

	// Write stage valid and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1  <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			wr_en_s1 <= cmd.walk && pix_we;
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + AddrW'(1);
			end
		end
	end

	// Store port drive: clearing pass or the write stage
	always_comb begin
		st_wr_en   = cmd.clear || wr_en_s1;
		st_wr_addr = cmd.clear ? clr_cnt_q : addr_s1;
		case (action_q)
			ACT_INVERT: st_wr_data = st_rd_data ^ PIXEL_MASK;
			ACT_GLYPH:  st_wr_data = text_color_q;
			default:    st_wr_data = back_color_q;
		endcase
		if (cmd.clear) begin
			st_wr_data = '0;
		end
	end

	assign st_rd_en   = cmd.walk;
	assign st_rd_addr = pix_addr;

	assign sts.clear_last = (clr_cnt_q == AddrW'(Depth - 1));
	assign sts.empty      = empty_q;
	assign sts.walk_last  = row_end && (cur_y_q == ylast_q);

	assign pixel_data = out_pixel_q;
	assign status     = out_status_q;

	`FBRE_ASSERT_IMPLY(a_walk_in_store, clk, arst_n, cmd.walk, int'(pix_addr) < Depth, "walk address beyond the store")
	`FBRE_ASSERT_IMPLY(a_clear_no_write, clk, arst_n, cmd.clear, !wr_en_s1, "pixel write during clearing pass")
	`FBRE_ASSERT_NEXT(a_read_no_write, clk, arst_n, cmd.walk && (action_q == ACT_READ), !wr_en_s1, "read command wrote a pixel")

endmodule

`default_nettype wire

// File: test/framebuffer_raster_engine_checker.sv
// Result checker for the frame buffer raster engine: mirrors the frame store and compares results.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_raster_engine_checker
	import fbre_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 128,
	parameter int unsigned MAX_HEIGHT = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wen,
	input  wire [REG_IDX_W-1:0] cfg_index,
	input  wire [PIX_W-1:0]     cfg_data,
	input  wire                 s_axis_tvalid,
	input  wire                 s_axis_tready,
	input  wire [47:0]          s_axis_tdata,   // pos_x, pos_y, size_w, size_h, glyph_bits
	input  wire [1:0]           s_axis_tuser,   // action
	input  wire                 m_axis_tvalid,
	input  wire                 m_axis_tready,
	input  wire [15:0]          m_axis_tdata,   // pixel_data
	input  wire [1:0]           m_axis_tuser,   // status
	output int                  errors,
	output int                  outstanding,
	output int                  results_seen,
	output int                  offscreen_reads,
	output int                  clipped_columns
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [1:0]       status;
	} result_t;

	// Shadow copy of the frame store and the register file
	logic [PIX_W-1:0] shadow_store [STORE_DEPTH];
	logic [PIX_W-1:0] back_color;
	logic [PIX_W-1:0] text_color;
	logic [7:0]       screen_width;
	logic [6:0]       screen_height;
	logic [7:0]       clip_x;
	logic [7:0]       clip_y;
	logic [7:0]       clip_width;
	logic [7:0]       clip_height;
	result_t          pending_results [$];

	function automatic int visible_width();
		return (screen_width > MAX_WIDTH) ? MAX_WIDTH : screen_width;
	endfunction

	function automatic int visible_height();
		return (screen_height > MAX_HEIGHT) ? MAX_HEIGHT : screen_height;
	endfunction

	function automatic bit on_screen(int x, int y);
		return x >= 0 && y >= 0 && x < visible_width() && y < visible_height();
	endfunction

	function automatic int pixel_addr(int x, int y);
		return (y * visible_width() + x) % STORE_DEPTH;
	endfunction

	// Fill or flip the part of a rectangle that lies on the screen
	function automatic void paint_rect(int x0, int y0, int w, int h, bit flip);
		int x1;
		int y1;
		x1 = x0 + w;
		y1 = y0 + h;
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x1 > visible_width()) x1 = visible_width();
		if (y1 > visible_height()) y1 = visible_height();
		for (int yy = y0; yy < y1; yy++)
			for (int xx = x0; xx < x1; xx++)
				if (flip)
					shadow_store[pixel_addr(xx, yy)] ^= PIXEL_MASK;
				else
					shadow_store[pixel_addr(xx, yy)] = back_color;
	endfunction

	// Apply one command to the shadow store and return its result
	function automatic result_t execute_command(logic [1:0] kind, logic [47:0] fields);
		result_t    res;
		int         x;
		int         y;
		int         w;
		int         h;
		int         left;
		int         right;
		int         top;
		int         bottom;
		logic [7:0] column;
		x = $signed(fields[8:0]);
		y = $signed(fields[17:9]);
		w = fields[25:18];
		h = fields[33:26];
		column = fields[41:34];
		res.pixel = '0;
		res.status = ST_DONE;
		case (action_t'(kind))
			ACT_FILL: paint_rect(x, y, w, h, 1'b0);
			ACT_INVERT: paint_rect(x, y, w, h, 1'b1);
			ACT_GLYPH: begin
				left = clip_x;
				right = left + clip_width;
				top = clip_y;
				bottom = top + clip_height;
				// drop the whole column when its anchor misses the clip window
				if (x < left || x >= right || y < top || y >= bottom)
					res.status = ST_CLIPPED;
				else
					for (int row = 0; row < int'(PAGE_ROWS); row++)
						if (column[row] && on_screen(x, y + row))
							shadow_store[pixel_addr(x, y + row)] = text_color;
			end
			default: begin
				if (on_screen(x, y))
					res.pixel = shadow_store[pixel_addr(x, y)];
				else
					res.status = ST_OFF_SCREEN;
			end
		endcase
		return res;
	endfunction

	// Track registers, predict on each command, compare on each result
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (shadow_store[i]) shadow_store[i] = '0;
			back_color = '0;
			text_color = '0;
			screen_width = 8'd128;
			screen_height = 7'd64;
			clip_x = '0;
			clip_y = '0;
			clip_width = 8'd128;
			clip_height = 8'd64;
			pending_results.delete();
			errors = 0;
			results_seen = 0;
			offscreen_reads = 0;
			clipped_columns = 0;
			outstanding <= 0;
		end else begin
			// check the result transaction against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result with no command waiting: pixel_data %h status %0d",
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata !== want.pixel) begin
						$error("pixel_data mismatch: expected %h, got %h", want.pixel, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, m_axis_tuser);
						errors++;
					end
				end
			end

			// mirror register writes
			if (cfg_wen) begin
				case (cfg_index)
					REG_BACK_COLOR:    back_color = cfg_data;
					REG_TEXT_COLOR:    text_color = cfg_data;
					REG_SCREEN_WIDTH:  screen_width = cfg_data[7:0];
					REG_SCREEN_HEIGHT: screen_height = cfg_data[6:0];
					REG_CLIP_X:        clip_x = cfg_data[7:0];
					REG_CLIP_Y:        clip_y = cfg_data[7:0];
					REG_CLIP_WIDTH:    clip_width = cfg_data[7:0];
					REG_CLIP_HEIGHT:   clip_height = cfg_data[7:0];
					default: ;
				endcase
			end

			// predict the command transaction
			if (s_axis_tvalid && s_axis_tready) begin
				want = execute_command(s_axis_tuser, s_axis_tdata);
				if (want.status == ST_OFF_SCREEN) offscreen_reads++;
				if (want.status == ST_CLIPPED) clipped_columns++;
				pending_results.push_back(want);
			end

			outstanding <= pending_results.size();
		end
	end

endmodule

`default_nettype wire

// File: test/framebuffer_raster_engine_tb.sv
// Stimulus and verdict for the frame buffer raster engine, with the checker beside the block.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_raster_engine_tb;
	import fbre_pkg::*;

	localparam int STALL_LIMIT     = 40000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int SETTLE_CYCLES   = 32;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [PIX_W-1:0]     cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata = '0;   // pos_x, pos_y, size_w, size_h, glyph_bits
	logic [1:0]           s_axis_tuser = '0;   // action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;        // pixel_data
	logic [1:0]           m_axis_tuser;        // status

	int errors;
	int outstanding;
	int results_seen;
	int offscreen_reads;
	int clipped_columns;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int aim_w = 128;
	int aim_h = 64;
	int fills = 0;
	int inverts = 0;
	int glyphs = 0;
	int reads = 0;

	framebuffer_raster_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	framebuffer_raster_engine_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.errors          (errors),
		.outstanding     (outstanding),
		.results_seen    (results_seen),
		.offscreen_reads (offscreen_reads),
		.clipped_columns (clipped_columns)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Abort when no transaction moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("framebuffer_raster_engine_tb failed");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Offer one command after a random gap and hold it until accepted
	task automatic send_command(input action_t act, input logic [8:0] x, input logic [8:0] y,
			input logic [7:0] w, input logic [7:0] h, input logic [7:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {6'b0, bits, h, w, y, x};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (act)
			ACT_FILL:   fills++;
			ACT_INVERT: inverts++;
			ACT_GLYPH:  glyphs++;
			default:    reads++;
		endcase
	endtask

	// Hold off commands until every result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Coordinate near the visible span, edges included
	function automatic logic [8:0] aim_coord(int span);
		int v;
		v = int'($urandom_range(span + 15)) - 8;
		return v[8:0];
	endfunction

	task automatic random_command();
		action_t    act;
		logic [8:0] x;
		logic [8:0] y;
		logic [7:0] w;
		logic [7:0] h;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 20)
			act = ACT_FILL;
		else if (pick < 38)
			act = ACT_INVERT;
		else if (pick < 65)
			act = ACT_GLYPH;
		else
			act = ACT_READ;
		if ($urandom_range(9) == 0) begin
			x = 9'($urandom_range(511));
			y = 9'($urandom_range(511));
		end else begin
			x = aim_coord(aim_w);
			y = aim_coord(aim_h);
		end
		// keep rectangles small, with the odd large one
		if ($urandom_range(39) == 0) begin
			w = 8'($urandom_range(255));
			h = 8'($urandom_range(255));
		end else begin
			w = 8'($urandom_range(12));
			h = 8'($urandom_range(12));
		end
		send_command(act, x, y, w, h, 8'($urandom_range(255)));
	endtask

	// Program every register for one phase
	task automatic apply_setting(input int phase);
		logic [15:0] back;
		logic [15:0] text;
		logic [7:0]  sw;
		logic [6:0]  sh;
		logic [7:0]  cx;
		logic [7:0]  cy;
		logic [7:0]  cw;
		logic [7:0]  ch;
		back = 16'($urandom_range(16'hffff));
		text = 16'($urandom_range(16'hffff));
		case (phase)
			0: begin sw = 128; sh = 64; cx = 0; cy = 0; cw = 128; ch = 64; end
			1: begin
				sw = 255; sh = 127; cx = 0; cy = 0; cw = 255; ch = 255;
				back = 16'hffff;
				text = 16'h0000;
			end
			2: begin sw = 1; sh = 1; cx = 0; cy = 0; cw = 1; ch = 1; end
			3: begin sw = 37; sh = 20; cx = 10; cy = 5; cw = 30; ch = 40; end
			4: begin sw = 0; sh = 0; cx = 255; cy = 255; cw = 255; ch = 255; end
			5: begin sw = 64; sh = 64; cx = 0; cy = 0; cw = 0; ch = 0; end
			6: begin
				sw = 128;
				sh = 64;
				cx = 8'($urandom_range(100));
				cy = 8'($urandom_range(50));
				cw = 8'($urandom_range(255));
				ch = 8'($urandom_range(255));
			end
			default: begin
				sw = 8'($urandom_range(128, 1));
				sh = 7'($urandom_range(64, 1));
				cx = 0;
				cy = 0;
				cw = 255;
				ch = 255;
				back = 16'h0000;
				text = 16'hffff;
			end
		endcase
		write_reg(REG_BACK_COLOR, back);
		write_reg(REG_TEXT_COLOR, text);
		write_reg(REG_SCREEN_WIDTH, {8'b0, sw});
		write_reg(REG_SCREEN_HEIGHT, {9'b0, sh});
		write_reg(REG_CLIP_X, {8'b0, cx});
		write_reg(REG_CLIP_Y, {8'b0, cy});
		write_reg(REG_CLIP_WIDTH, {8'b0, cw});
		write_reg(REG_CLIP_HEIGHT, {8'b0, ch});
		aim_w = (sw > 128) ? 128 : sw;
		aim_h = (sh > 64) ? 64 : sh;
	endtask

	// Main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed commands on the reset geometry
		write_reg(REG_BACK_COLOR, 16'hf81f);
		write_reg(REG_TEXT_COLOR, 16'h07e0);
		send_command(ACT_READ, 0, 0, 0, 0, 0);
		send_command(ACT_READ, 127, 63, 0, 0, 0);
		send_command(ACT_READ, -1, 0, 0, 0, 0);
		send_command(ACT_READ, 0, 64, 0, 0, 0);
		send_command(ACT_READ, -256, -256, 0, 0, 0);
		send_command(ACT_READ, 255, 255, 0, 0, 0);
		send_command(ACT_FILL, -256, -256, 255, 255, 0);
		send_command(ACT_FILL, -5, -5, 10, 10, 0);
		send_command(ACT_FILL, 120, 60, 255, 255, 0);
		send_command(ACT_FILL, 10, 10, 0, 20, 0);
		send_command(ACT_INVERT, 0, 0, 128, 64, 0);
		send_command(ACT_INVERT, 100, 30, 0, 0, 0);
		send_command(ACT_GLYPH, 5, 10, 0, 0, 8'hff);
		send_command(ACT_GLYPH, 5, 60, 0, 0, 8'hff);
		send_command(ACT_GLYPH, -1, 0, 0, 0, 8'hff);
		send_command(ACT_GLYPH, 128, 0, 0, 0, 8'hff);
		send_command(ACT_GLYPH, 0, 64, 0, 0, 8'hff);
		send_command(ACT_GLYPH, 127, 56, 0, 0, 8'ha5);
		send_command(ACT_GLYPH, 3, 3, 0, 0, 8'h00);
		send_command(ACT_INVERT, 127, 63, 255, 255, 0);
		send_command(ACT_READ, 0, 0, 0, 0, 0);
		send_command(ACT_READ, 127, 63, 0, 0, 0);
		send_command(ACT_READ, 5, 12, 0, 0, 0);
		send_command(ACT_READ, 4, 4, 0, 0, 0);
		send_command(ACT_READ, 127, 56, 0, 0, 0);

		// random phases, each with its own geometry and one of four idling mixes
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_setting(phase);
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2) drain();
				random_command();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d commands: %0d fill, %0d invert, %0d glyph, %0d read, over %0d geometries",
			fills + inverts + glyphs + reads, fills, inverts, glyphs, reads, PHASES + 1);
		$display("checked %0d results: %0d off-screen reads, %0d clipped glyph columns",
			results_seen, offscreen_reads, clipped_columns);
		if (errors == 0 && outstanding == 0)
			$display("framebuffer_raster_engine_tb passed");
		else
			$display("framebuffer_raster_engine_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/fbre_pkg.sv
rtl/fbre_store.sv
rtl/fbre_ctrl.sv
rtl/fbre_datapath.sv
rtl/framebuffer_raster_engine.sv
test/framebuffer_raster_engine_checker.sv
test/framebuffer_raster_engine_tb.sv
